@@ hdl/xrd_pkg.sv @@
// ----------------------------------------------------------------------------
// xrd_pkg
// Shared types, constants and the xorshift step for the random draw block.
// ----------------------------------------------------------------------------
package xrd_pkg;

    localparam logic [31:0] DEFAULT_SEED = 32'h9E37_79B9;
    localparam int          SHIFT_A      = 13;
    localparam int          SHIFT_B      = 17;
    localparam int          SHIFT_C      = 5;

    localparam int WORD_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int CNT_W   = $clog2(WORD_W);

    // Request codes for func
    localparam logic FUNC_RAW    = 1'b0;
    localparam logic FUNC_RANGED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  dividend;
        logic [LIMIT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LIMIT_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] t;
        t = x ^ (x << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

@@ hdl/xrd_if.sv @@
// ----------------------------------------------------------------------------
// xrd_if
// Valid/ready channels for draw requests and draw results.
// ----------------------------------------------------------------------------
interface xrd_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] range_limit;

    modport source (output valid, output func, output range_limit, input ready);
    modport sink   (input valid, input func, input range_limit, output ready);
endinterface

interface xrd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/xrd_div.sv @@
// ----------------------------------------------------------------------------
// xrd_div
// Radix-2 restoring remainder unit: 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xrd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  xrd_pkg::div_req_t ctl,
    output xrd_pkg::div_rsp_t sts
);
    import xrd_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   dvd_reg,   dvd_next;
    logic [LIMIT_W-1:0]  dsr_reg,   dsr_next;
    logic [LIMIT_W-1:0]  rem_reg,   rem_next;
    logic [LIMIT_W:0]    trial;
    logic [LIMIT_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        if (ctl.start && !busy_reg)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            dvd_next   = ctl.dividend;
            dsr_next   = ctl.divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[LIMIT_W-1:0];
            else
                rem_next = trial[LIMIT_W-1:0];
            dvd_next   = {dvd_reg[WORD_W-2:0], 1'b0};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign sts.done      = done_reg;
    assign sts.remainder = rem_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder unit flags done while still busy");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && dsr_reg != '0) |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("done raised without a run");

endmodule

@@ hdl/xorshift32_random_draw_top.sv @@
// ----------------------------------------------------------------------------
// xorshift32_random_draw_top
// Xorshift32 generator (13/17/5) with raw and ranged draws.
// ----------------------------------------------------------------------------
// Usage:
//   seed_we/seed_wdata load the generator state; a zero seed loads
//   0x9E3779B9. Write only while no request is in flight.
//   req carries func (0 raw, 1 ranged) and range_limit. rsp returns one
//   value per request, in order.
//   A raw draw, or a ranged draw with limit zero, goes from the idle state
//   to the done state; a ranged draw first passes through the divide state,
//   where the one-bit-per-cycle remainder unit runs over the 32-bit dividend.
//   req.ready is high only while the sequencer is idle, so a new request
//   is taken only after the last result has left the sequencer.
//   The result sits in an output register; the next request is taken while
//   it waits, and a finished result holds in the sequencer until the output
//   register frees up.
//   Reset: state becomes 0x9E3779B9, no result pending, sequencer idle.
// ----------------------------------------------------------------------------
module xorshift32_random_draw_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    xrd_req_if.sink     req,
    xrd_rsp_if.source   rsp
);
    import xrd_pkg::*;

    state_t              state_reg,     state_next;
    logic [WORD_W-1:0]   gen_reg,       gen_next;
    logic [WORD_W-1:0]   result_reg,    result_next;
    logic [LIMIT_W-1:0]  limit_reg,     limit_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_value_reg, out_value_next;
    logic [WORD_W-1:0]   drawn;
    logic                req_fire;
    div_req_t            div_ctl;
    div_rsp_t            div_sts;

    xrd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    assign drawn     = xorshift(gen_reg);
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        state_next       = state_reg;
        gen_next         = gen_reg;
        result_next      = result_reg;
        limit_next       = limit_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = drawn;
        div_ctl.divisor  = req.range_limit;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (seed_we)
                    gen_next = (seed_wdata == '0) ? DEFAULT_SEED : seed_wdata;
                if (req_fire)
                begin
                    limit_next = req.range_limit;
                    if (req.func == FUNC_RAW)
                    begin
                        gen_next    = drawn;
                        result_next = drawn;
                        state_next  = ST_DONE;
                    end
                    else if (req.range_limit == '0)
                    begin
                        // zero limit: result 0, state untouched
                        result_next = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        gen_next      = drawn;
                        div_ctl.start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_sts.done)
                begin
                    result_next = {{(WORD_W-LIMIT_W){1'b0}}, div_sts.remainder};
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= DEFAULT_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        limit_reg     <= limit_next;
        out_value_reg <= out_value_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

    a_divide_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (limit_reg != '0))
        else $error("remainder run with zero limit");

    a_request_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_DIVIDE))
        else $error("remainder done outside divide state");

    a_ranged_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && div_sts.done)
            |=> (result_reg[WORD_W-1:LIMIT_W] == '0))
        else $error("ranged result has upper bits set");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the xorshift32 random draw block. A short directed table covers
// the reset state, zero and extreme seeds, zero and extreme limits and raw
// draws that ignore the limit. Several random phases follow, each started
// by a seed load. Every result is compared in order against its typed-in
// value or a cycle-free model of the generator that runs inside the bench.
// ----------------------------------------------------------------------------
module tb;
    import xrd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 76;
    localparam int HOLD_LEN     = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_CYCLES   = 400000;

    typedef enum logic {
        ROW_DRAW,
        ROW_SEED
    } row_kind_t;

    // word is the typed-in result of a draw row (when fixed) or the seed
    typedef struct packed {
        row_kind_t   kind;
        logic        func;
        logic [15:0] limit;
        logic        fixed;
        logic [31:0] word;
    } plan_row_t;

    localparam int PLAN_ROWS = 22;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_DRAW, FUNC_RAW,    16'h0000, 1'b1, 32'h510C_4619},
        '{ROW_DRAW, FUNC_RANGED, 16'h0000, 1'b1, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h0001, 1'b1, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'hFFFF, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h8000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h0002, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RAW,    16'hFFFF, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h5555, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'hAAAA, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h0000, 1'b1, 32'h0000_0000},
        '{ROW_SEED, FUNC_RAW,    16'h0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RAW,    16'h0000, 1'b1, 32'h510C_4619},
        '{ROW_SEED, FUNC_RAW,    16'h0000, 1'b0, 32'hFFFF_FFFF},
        '{ROW_DRAW, FUNC_RAW,    16'h0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'hFFFF, 1'b0, 32'h0000_0000},
        '{ROW_SEED, FUNC_RAW,    16'h0000, 1'b0, 32'h0000_0001},
        '{ROW_DRAW, FUNC_RAW,    16'h0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h0003, 1'b0, 32'h0000_0000},
        '{ROW_SEED, FUNC_RAW,    16'h0000, 1'b0, 32'h8000_0000},
        '{ROW_DRAW, FUNC_RAW,    16'h0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RANGED, 16'h0001, 1'b1, 32'h0000_0000},
        '{ROW_DRAW, FUNC_RAW,    16'h0000, 1'b0, 32'h0000_0000}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        seed_we;
    logic [31:0] seed_wdata;

    xrd_req_if req_bus ();
    xrd_rsp_if rsp_bus ();

    // generator copy and seed register copy
    logic [31:0] draw_state;
    logic [31:0] seed_reg;

    logic [31:0] value_q [$];

    int cycles;
    int n_req;
    int n_ranged;
    int n_zero_lim;
    int n_seeds;
    int n_results;
    int n_errors;

    bit steady;
    int hold_reqs;
    int hold_seen;
    int hold_cnt;
    int stall_cnt;

    xorshift32_random_draw_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .req        (req_bus),
        .rsp        (rsp_bus)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, value_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] predict_draw(input logic func, input logic [15:0] limit);
        logic [31:0] x;
        // zero limit leaves the generator where it is
        if (func == FUNC_RANGED && limit == 16'd0)
            return 32'd0;
        x = draw_state;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        draw_state = x;
        if (func == FUNC_RAW)
            return x;
        return x % {16'd0, limit};
    endfunction

    // Lower valid and wait on the clock until no result is pending
    task automatic pause_until_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (value_q.size() != 0);
    endtask

    task automatic load_seed(input logic [31:0] s);
        pause_until_drained();
        repeat (2) @(posedge clk);
        seed_we    <= 1'b1;
        seed_wdata <= s;
        @(posedge clk);
        seed_we    <= 1'b0;
        seed_wdata <= $urandom;
        seed_reg   = s;
        draw_state = (s == 32'd0) ? DEFAULT_SEED : s;
        n_seeds++;
    endtask

    task automatic send_draw(input logic func, input logic [15:0] limit,
                             input logic fixed, input logic [31:0] fixed_val);
        logic [31:0] want;
        int          gap;
        req_bus.valid       <= 1'b1;
        req_bus.func        <= func;
        req_bus.range_limit <= limit;
        do
            @(posedge clk);
        while (!req_bus.ready);
        want = predict_draw(func, limit);
        value_q.push_back(fixed ? fixed_val : want);
        n_req++;
        if (func == FUNC_RANGED)
        begin
            n_ranged++;
            if (limit == 16'd0)
                n_zero_lim++;
        end
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            // scramble the idle payload
            req_bus.valid       <= 1'b0;
            req_bus.func        <= 1'($urandom);
            req_bus.range_limit <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_sink
        logic [31:0] want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            n_results++;
            if (value_q.size() == 0)
            begin
                $error("value: no result expected, got %08h", rsp_bus.value);
                n_errors++;
            end
            else
            begin
                want = value_q.pop_front();
                if (rsp_bus.value !== want)
                begin
                    $error("value: expected %08h, got %08h", want, rsp_bus.value);
                    n_errors++;
                end
            end
        end
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_cnt  = HOLD_LEN;
        end
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_bus.ready <= 1'b0;
        end
        else if (steady)
            rsp_bus.ready <= 1'b1;
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            stall_cnt = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_bus.ready <= (stall_cnt == 0);
        end
    end

    initial
    begin : stimulus
        logic        func;
        logic [15:0] limit;
        logic [31:0] s;
        int          r;
        rst_n               <= 1'b0;
        seed_we             <= 1'b0;
        seed_wdata          <= 32'd0;
        req_bus.valid       <= 1'b0;
        req_bus.func        <= FUNC_RAW;
        req_bus.range_limit <= 16'd0;
        draw_state = DEFAULT_SEED;
        seed_reg   = 32'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_SEED)
                load_seed(PLAN[i].word);
            else
                send_draw(PLAN[i].func, PLAN[i].limit, PLAN[i].fixed, PLAN[i].word);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                1:       s = 32'd0;
                2:       s = 32'hFFFF_FFFF;
                default: s = $urandom;
            endcase
            load_seed(s);
            steady = (phase == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // long receiver hold while requests keep coming
                if (phase == 1 && k == 20)
                    hold_reqs <= hold_reqs + 1;
                if ((phase == 2 && k == 40) || (!steady && $urandom_range(0, 49) == 0))
                    pause_until_drained();
                // during the hold, keep to quick raw draws so the block backs up
                func = (phase == 1 && k >= 20 && k < 30) ? FUNC_RAW : 1'($urandom);
                r = $urandom_range(0, 15);
                case (r)
                    0:       limit = 16'd0;
                    1:       limit = 16'd1;
                    2:       limit = 16'hFFFF;
                    3:       limit = 16'd1 << $urandom_range(0, 15);
                    4, 5, 6: limit = 16'($urandom_range(2, 20));
                    default: limit = 16'($urandom);
                endcase
                send_draw(func, limit, 1'b0, 32'd0);
            end
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d draw requests (%0d ranged, %0d with zero limit) over %0d seed loads,",
                 n_req, n_ranged, n_zero_lim, n_seeds);
        $display("checked %0d results in %0d cycles; last seed %08h.", n_results, cycles, seed_reg);
        if (n_errors == 0 && value_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
